/* rtl/tprt_pkg.sv */
package tprt_pkg;

    localparam int FREQ_W  = 14;
    localparam int POWER_W = 8;
    localparam int STAMP_W = 32;
    localparam int TOUT_W  = 31;
    localparam int GEO_W   = 16;
    localparam int FIX_N   = 6;

    // Item kinds carried on s_tuser.
    localparam logic [2:0] ACT_TICK  = 3'd0;
    localparam logic [2:0] ACT_SWEEP = 3'd1;
    localparam logic [2:0] ACT_LOAD  = 3'd2;
    localparam logic [2:0] ACT_WRITE = 3'd3;
    localparam logic [2:0] ACT_CHECK = 3'd4;
    localparam logic [2:0] ACT_QUERY = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_PERM  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_COUNT = 2'd3;

    localparam logic [1:0] CFG_REGION  = 2'd0;
    localparam logic [1:0] CFG_AFC_EN  = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT = 2'd2;

    localparam logic [1:0] REGION_FCC  = 2'd1;
    localparam logic [1:0] REGION_ETSI = 2'd2;

    // Fixed rules of both regions, listed in priority order within each region.
    localparam logic [1:0] FIX_REGION [0:FIX_N-1] = '{
        REGION_FCC, REGION_FCC, REGION_FCC, REGION_FCC, REGION_ETSI, REGION_ETSI};
    localparam logic [FREQ_W-1:0] FIX_LO [0:FIX_N-1] = '{
        14'd5925, 14'd6425, 14'd6525, 14'd6875, 14'd5925, 14'd6425};
    localparam logic [FREQ_W-1:0] FIX_HI [0:FIX_N-1] = '{
        14'd6425, 14'd6525, 14'd6875, 14'd7125, 14'd6425, 14'd7125};
    localparam logic [POWER_W-1:0] FIX_PWR [0:FIX_N-1] = '{
        8'd24, 8'd24, 8'd30, 8'd30, 8'd23, 8'd23};
    localparam logic FIX_AFC_ONLY [0:FIX_N-1] = '{
        1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

    typedef struct packed {
        logic               hit;
        logic               afc_only;
        logic [POWER_W-1:0] pwr;
    } fix_t;

    typedef struct packed {
        logic band_hit;
        logic area_hit;
        logic expired;
    } eval_t;

    function automatic fix_t fixed_match(input logic [1:0] region,
                                         input logic [FREQ_W-1:0] lo,
                                         input logic [FREQ_W-1:0] hi);
        fix_t res;
        res = '0;
        // Walk backwards so that the earliest matching rule wins.
        for (int i = FIX_N - 1; i >= 0; i--) begin
            if (region == FIX_REGION[i] && lo >= FIX_LO[i] && hi <= FIX_HI[i]) begin
                res.hit      = 1'b1;
                res.afc_only = FIX_AFC_ONLY[i];
                res.pwr      = FIX_PWR[i];
            end
        end
        return res;
    endfunction

endpackage

/* rtl/tprt_ram.sv */
module tprt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                           aclk,
    input  logic                                           we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
    input  logic [WIDTH-1:0]                               wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
    output logic [WIDTH-1:0]                               rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/tprt_eval.sv */
module tprt_eval #(
    parameter int AREA_W = 16
) (
    input  logic [tprt_pkg::FREQ_W-1:0]  band_lo,
    input  logic [tprt_pkg::FREQ_W-1:0]  band_hi,
    input  logic [AREA_W-1:0]            geo,
    input  logic [tprt_pkg::FREQ_W-1:0]  rule_start,
    input  logic [tprt_pkg::FREQ_W-1:0]  rule_end,
    input  logic [AREA_W-1:0]            rule_area,
    input  logic [tprt_pkg::STAMP_W-1:0] rule_stamp,
    input  logic [tprt_pkg::TOUT_W-1:0]  timeout,
    input  logic [tprt_pkg::STAMP_W-1:0] now,
    output tprt_pkg::eval_t              result
);

    logic [tprt_pkg::STAMP_W-1:0] age_margin;

    // A negative margin in two's complement means the rule has outlived its timeout,
    // which stays correct across a wrap of the tick counter.
    assign age_margin = rule_stamp + {1'b0, timeout} - now;

    always_comb begin
        result.band_hit = (band_lo >= rule_start) && (band_hi <= rule_end);
        result.area_hit = (rule_area == geo);
        result.expired  = age_margin[tprt_pkg::STAMP_W-1];
    end

endmodule

/* rtl/tx_power_limit_rule_table.sv */
// Channel  | Ports                         | Beat contents
// ---------+-------------------------------+---------------------------------------------
// input    | s_tvalid s_tready s_tdata/user| one command: tick, sweep, load, write,
//          |                               | band check or power query
// result   | m_tvalid m_tready m_tdata     | status and allowed power, one per command
// config   | cfg_we cfg_idx cfg_wdata      | region, AFC enable, AFC timeout
//
// A tick, load, rule write, band check or unused command goes through the execute and
// result steps; a power query with AFC off also goes through the fixed-rule step. A sweep
// walks all loaded rules, and a power query with AFC on walks them up to the first match
// before the fixed-rule step: the dynamic rules sit in one RAM with one read port, read
// one entry per cycle. Reset (aresetn, synchronous) clears all valid marks at once.
// A new command is accepted while a result still waits in the output register.

module tx_power_limit_rule_table #(
    parameter int MAX_AFC_RULES = 16,
    parameter int AREA_BITS     = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [13:0] freq_low, [27:14] freq_high, [32:28] entry_index, [40:33] entry_power,
    // [56:41] geo_code, [57] geo_given, [63:58] zero
    input  logic [63:0] s_tdata,
    // [2:0] action
    input  logic [2:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] status, [9:2] power_dbm, [15:10] zero
    output logic [15:0] m_tdata,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [30:0] cfg_wdata
);

    localparam int AW   = (AREA_BITS < tprt_pkg::GEO_W) ? AREA_BITS : tprt_pkg::GEO_W;
    localparam int IW   = (MAX_AFC_RULES > 1) ? $clog2(MAX_AFC_RULES) : 1;
    localparam int CW   = $clog2(MAX_AFC_RULES + 1);
    localparam int FW   = tprt_pkg::FREQ_W;
    localparam int PW   = tprt_pkg::POWER_W;
    localparam int SW   = tprt_pkg::STAMP_W;
    localparam int OFF_END   = FW;
    localparam int OFF_PWR   = 2 * FW;
    localparam int OFF_AREA  = OFF_PWR + PW;
    localparam int OFF_STAMP = OFF_AREA + AW;
    localparam int EW        = OFF_STAMP + SW;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXEC   = 5'b00010,
        S_WALK   = 5'b00100,
        S_FIX    = 5'b01000,
        S_RESULT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [2:0]    act_reg, act_next;
    logic [FW-1:0] lo_reg, lo_next;
    logic [FW-1:0] hi_reg, hi_next;
    logic [4:0]    idx_reg, idx_next;
    logic [PW-1:0] pwr_reg, pwr_next;
    logic [AW-1:0] geo_reg, geo_next;
    logic          geo_given_reg, geo_given_next;

    logic [1:0]                  region_reg, region_next;
    logic                        afc_en_reg, afc_en_next;
    logic [tprt_pkg::TOUT_W-1:0] timeout_reg, timeout_next;
    logic [SW-1:0]               now_reg, now_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [MAX_AFC_RULES-1:0]    valid_reg, valid_next;

    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic          ev_valid_reg, ev_valid_next;
    logic [IW-1:0] ev_idx_reg, ev_idx_next;
    logic          found_reg, found_next;
    logic [PW-1:0] afc_pwr_reg, afc_pwr_next;

    logic [1:0]    res_status_reg, res_status_next;
    logic [PW-1:0] res_power_reg, res_power_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [1:0]    m_status_reg, m_status_next;
    logic [PW-1:0] m_power_reg, m_power_next;

    logic          ram_we;
    logic [EW-1:0] ram_wdata;
    logic [EW-1:0] ram_rdata;
    logic [IW-1:0] ram_raddr;

    logic            issue;
    logic            entry_valid;
    logic [PW-1:0]   query_pwr;
    tprt_pkg::fix_t  fix;
    tprt_pkg::eval_t ev;

    tprt_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_AFC_RULES)
    ) u_rules (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_reg[IW-1:0]),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tprt_eval #(
        .AREA_W (AW)
    ) u_eval (
        .band_lo    (lo_reg),
        .band_hi    (hi_reg),
        .geo        (geo_reg),
        .rule_start (ram_rdata[FW-1:0]),
        .rule_end   (ram_rdata[OFF_END +: FW]),
        .rule_area  (ram_rdata[OFF_AREA +: AW]),
        .rule_stamp (ram_rdata[OFF_STAMP +: SW]),
        .timeout    (timeout_reg),
        .now        (now_reg),
        .result     (ev)
    );

    assign ram_wdata   = {now_reg, geo_reg, pwr_reg, hi_reg, lo_reg};
    assign ram_raddr   = rd_idx_reg[IW-1:0];
    assign issue       = (rd_idx_reg < count_reg);
    assign entry_valid = valid_reg[ev_idx_reg];
    assign fix         = tprt_pkg::fixed_match(region_reg, lo_reg, hi_reg);

    // Fixed rule lowers the AFC power; it stands alone when no AFC power was found.
    always_comb begin
        query_pwr = found_reg ? afc_pwr_reg : '0;
        if (fix.hit && (query_pwr == '0 || fix.pwr < query_pwr)) begin
            query_pwr = fix.pwr;
        end
    end

    always_comb begin
        state_next      = state_reg;
        act_next        = act_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        idx_next        = idx_reg;
        pwr_next        = pwr_reg;
        geo_next        = geo_reg;
        geo_given_next  = geo_given_reg;
        region_next     = region_reg;
        afc_en_next     = afc_en_reg;
        timeout_next    = timeout_reg;
        now_next        = now_reg;
        count_next      = count_reg;
        valid_next      = valid_reg;
        rd_idx_next     = rd_idx_reg;
        ev_valid_next   = ev_valid_reg;
        ev_idx_next     = ev_idx_reg;
        found_next      = found_reg;
        afc_pwr_next    = afc_pwr_reg;
        res_status_next = res_status_reg;
        res_power_next  = res_power_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_status_next   = m_status_reg;
        m_power_next    = m_power_reg;
        ram_we          = 1'b0;

        if (cfg_we) begin
            case (cfg_idx)
                tprt_pkg::CFG_REGION:  region_next  = cfg_wdata[1:0];
                tprt_pkg::CFG_AFC_EN:  afc_en_next  = cfg_wdata[0];
                tprt_pkg::CFG_TIMEOUT: timeout_next = cfg_wdata;
                default: ;
            endcase
        end

        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    act_next       = s_tuser;
                    lo_next        = s_tdata[13:0];
                    hi_next        = s_tdata[27:14];
                    idx_next       = s_tdata[32:28];
                    pwr_next       = s_tdata[40:33];
                    geo_next       = s_tdata[41 +: AW];
                    geo_given_next = s_tdata[57];
                    state_next     = S_EXEC;
                end
            end
            S_EXEC: begin
                res_status_next = tprt_pkg::ST_OK;
                res_power_next  = '0;
                rd_idx_next     = '0;
                ev_valid_next   = 1'b0;
                found_next      = 1'b0;
                afc_pwr_next    = '0;
                state_next      = S_RESULT;
                case (act_reg)
                    tprt_pkg::ACT_TICK: begin
                        now_next = now_reg + 1'b1;
                    end
                    tprt_pkg::ACT_SWEEP: begin
                        state_next = S_WALK;
                    end
                    tprt_pkg::ACT_LOAD: begin
                        if ({1'b0, idx_reg} > 6'(MAX_AFC_RULES)) begin
                            res_status_next = tprt_pkg::ST_COUNT;
                        end else begin
                            valid_next = '0;
                            count_next = CW'(idx_reg);
                        end
                    end
                    tprt_pkg::ACT_WRITE: begin
                        if (6'(idx_reg) >= 6'(count_reg)) begin
                            res_status_next = tprt_pkg::ST_COUNT;
                        end else begin
                            ram_we = 1'b1;
                            valid_next[idx_reg[IW-1:0]] = 1'b1;
                        end
                    end
                    tprt_pkg::ACT_CHECK: begin
                        if (!fix.hit) begin
                            res_status_next = tprt_pkg::ST_RANGE;
                        end else if (fix.afc_only && !afc_en_reg) begin
                            res_status_next = tprt_pkg::ST_PERM;
                        end
                    end
                    tprt_pkg::ACT_QUERY: begin
                        state_next = afc_en_reg ? S_WALK : S_FIX;
                    end
                    default: ;
                endcase
            end
            S_WALK: begin
                // The read issued in one cycle is evaluated in the next.
                if (issue) begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                ev_valid_next = issue;
                ev_idx_next   = rd_idx_reg[IW-1:0];
                if (act_reg == tprt_pkg::ACT_SWEEP) begin
                    if (ev_valid_reg && entry_valid && ev.expired) begin
                        valid_next[ev_idx_reg] = 1'b0;
                    end
                    if (!issue && !ev_valid_reg) begin
                        state_next = S_RESULT;
                    end
                end else begin
                    if (ev_valid_reg && entry_valid && ev.band_hit &&
                        (!geo_given_reg || ev.area_hit)) begin
                        found_next    = 1'b1;
                        afc_pwr_next  = ram_rdata[OFF_PWR +: PW];
                        ev_valid_next = 1'b0;
                        state_next    = S_FIX;
                    end else if (!issue && !ev_valid_reg) begin
                        state_next = S_FIX;
                    end
                end
            end
            S_FIX: begin
                res_power_next  = query_pwr;
                res_status_next = (query_pwr == '0) ? tprt_pkg::ST_RANGE : tprt_pkg::ST_OK;
                state_next      = S_RESULT;
            end
            S_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_status_next = res_status_reg;
                    m_power_next  = res_power_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            region_reg   <= '0;
            afc_en_reg   <= 1'b1;
            timeout_reg  <= 31'd1000;
            now_reg      <= '0;
            count_reg    <= '0;
            valid_reg    <= '0;
            rd_idx_reg   <= '0;
            ev_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            region_reg   <= region_next;
            afc_en_reg   <= afc_en_next;
            timeout_reg  <= timeout_next;
            now_reg      <= now_next;
            count_reg    <= count_next;
            valid_reg    <= valid_next;
            rd_idx_reg   <= rd_idx_next;
            ev_valid_reg <= ev_valid_next;
            found_reg    <= found_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg        <= act_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        idx_reg        <= idx_next;
        pwr_reg        <= pwr_next;
        geo_reg        <= geo_next;
        geo_given_reg  <= geo_given_next;
        ev_idx_reg     <= ev_idx_next;
        afc_pwr_reg    <= afc_pwr_next;
        res_status_reg <= res_status_next;
        res_power_reg  <= res_power_next;
        m_status_reg   <= m_status_next;
        m_power_reg    <= m_power_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, m_power_reg, m_status_reg};

`ifndef ASSERT_OFF
    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        6'(count_reg) <= 6'(MAX_AFC_RULES))
        else $error("rule count exceeds table depth");

    a_eval_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ev_valid_reg |-> (6'(ev_idx_reg) < 6'(count_reg)))
        else $error("walk evaluates a slot beyond the loaded count");

    a_result_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_RESULT))
        else $error("result beat raised outside the result step");

    a_query_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIX) |=> ((res_power_reg == '0) == (res_status_reg == tprt_pkg::ST_RANGE)))
        else $error("power query status disagrees with its power");
`endif

endmodule

/* sim/tprt_limit_checker.sv */
module tprt_limit_checker
    import tprt_pkg::*;
#(
    parameter int MAX_AFC_RULES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    input  logic        s_tready,
    // [13:0] freq_low, [27:14] freq_high, [32:28] entry_index, [40:33] entry_power,
    // [56:41] geo_code, [57] geo_given, [63:58] zero
    input  logic [63:0] s_tdata,
    // [2:0] action
    input  logic [2:0]  s_tuser,

    input  logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] status, [9:2] power_dbm, [15:10] zero
    input  logic [15:0] m_tdata,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [30:0] cfg_wdata,

    output int          errors,
    output int          pending,
    output int          checked
);

    localparam logic [FREQ_W-1:0] EDGE_LOW = 14'd5925;
    localparam logic [FREQ_W-1:0] EDGE_U5  = 14'd6425;
    localparam logic [FREQ_W-1:0] EDGE_U6  = 14'd6525;
    localparam logic [FREQ_W-1:0] EDGE_U7  = 14'd6875;
    localparam logic [FREQ_W-1:0] EDGE_TOP = 14'd7125;

    localparam logic [POWER_W-1:0] LIM_FCC_LOW  = 8'd24;
    localparam logic [POWER_W-1:0] LIM_FCC_HIGH = 8'd30;
    localparam logic [POWER_W-1:0] LIM_ETSI     = 8'd23;

    typedef struct packed {
        logic               hit;
        logic               afc_only;
        logic [POWER_W-1:0] pwr;
    } fixed_lim_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [POWER_W-1:0] power;
    } reply_t;

    // Register copies.
    logic [1:0]          region_q;
    logic                afc_on_q;
    logic [TOUT_W-1:0]   tout_q;

    // Rule table copy.
    logic [STAMP_W-1:0]  now_q;
    logic [4:0]          count_q;
    logic                valid_q [MAX_AFC_RULES];
    logic [FREQ_W-1:0]   start_q [MAX_AFC_RULES];
    logic [FREQ_W-1:0]   end_q   [MAX_AFC_RULES];
    logic [POWER_W-1:0]  pow_q   [MAX_AFC_RULES];
    logic [GEO_W-1:0]    area_q  [MAX_AFC_RULES];
    logic [STAMP_W-1:0]  stamp_q [MAX_AFC_RULES];

    reply_t replies_due [$];

    // First fixed rule of the selected region that holds the band.
    function automatic fixed_lim_t region_limit(input logic [1:0] reg_sel,
                                                input logic [FREQ_W-1:0] lo,
                                                input logic [FREQ_W-1:0] hi);
        fixed_lim_t lim;
        lim = '0;
        if (reg_sel == REGION_FCC) begin
            if (lo >= EDGE_LOW && hi <= EDGE_U5)
                lim = {1'b1, 1'b0, LIM_FCC_LOW};
            else if (lo >= EDGE_U5 && hi <= EDGE_U6)
                lim = {1'b1, 1'b0, LIM_FCC_LOW};
            else if (lo >= EDGE_U6 && hi <= EDGE_U7)
                lim = {1'b1, 1'b1, LIM_FCC_HIGH};
            else if (lo >= EDGE_U7 && hi <= EDGE_TOP)
                lim = {1'b1, 1'b1, LIM_FCC_HIGH};
        end else if (reg_sel == REGION_ETSI) begin
            if (lo >= EDGE_LOW && hi <= EDGE_U5)
                lim = {1'b1, 1'b0, LIM_ETSI};
            else if (lo >= EDGE_U5 && hi <= EDGE_TOP)
                lim = {1'b1, 1'b1, LIM_ETSI};
        end
        return lim;
    endfunction

    task automatic apply_command(input  logic [63:0]        d,
                                 input  logic [2:0]         act,
                                 output logic [1:0]         st,
                                 output logic [POWER_W-1:0] pw);
        logic [FREQ_W-1:0]  lo;
        logic [FREQ_W-1:0]  hi;
        logic [4:0]         idx;
        logic [POWER_W-1:0] pwr;
        logic [GEO_W-1:0]   geo;
        logic               given;
        logic [STAMP_W-1:0] slack;
        logic               found;
        fixed_lim_t         lim;
        lo    = d[13:0];
        hi    = d[27:14];
        idx   = d[32:28];
        pwr   = d[40:33];
        geo   = d[56:41];
        given = d[57];
        st    = ST_OK;
        pw    = '0;
        case (act)
            ACT_TICK: begin
                now_q = now_q + 1'b1;
            end
            ACT_SWEEP: begin
                // A rule is stale once stamp + timeout lies behind now, compared
                // as a wrapping signed difference.
                for (int i = 0; i < MAX_AFC_RULES; i++) begin
                    slack = stamp_q[i] + {1'b0, tout_q} - now_q;
                    if (i < count_q && valid_q[i] && slack[STAMP_W-1])
                        valid_q[i] = 1'b0;
                end
            end
            ACT_LOAD: begin
                if (idx > MAX_AFC_RULES) begin
                    st = ST_COUNT;
                end else begin
                    foreach (valid_q[i]) valid_q[i] = 1'b0;
                    count_q = idx;
                end
            end
            ACT_WRITE: begin
                if (idx >= count_q) begin
                    st = ST_COUNT;
                end else begin
                    start_q[idx] = lo;
                    end_q[idx]   = hi;
                    pow_q[idx]   = pwr;
                    area_q[idx]  = geo;
                    stamp_q[idx] = now_q;
                    valid_q[idx] = 1'b1;
                end
            end
            ACT_CHECK: begin
                lim = region_limit(region_q, lo, hi);
                if (!lim.hit)
                    st = ST_RANGE;
                else if (lim.afc_only && !afc_on_q)
                    st = ST_PERM;
            end
            ACT_QUERY: begin
                found = 1'b0;
                if (afc_on_q) begin
                    for (int i = 0; i < MAX_AFC_RULES; i++) begin
                        if (!found && i < count_q && valid_q[i] && lo >= start_q[i] &&
                            hi <= end_q[i] && (!given || area_q[i] == geo)) begin
                            pw    = pow_q[i];
                            found = 1'b1;
                        end
                    end
                end
                // The fixed rule caps the dynamic power, or stands alone without one.
                lim = region_limit(region_q, lo, hi);
                if (lim.hit && (pw == '0 || lim.pwr < pw))
                    pw = lim.pwr;
                if (pw == '0)
                    st = ST_RANGE;
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge aclk) begin : watch
        logic [1:0]         st;
        logic [POWER_W-1:0] pw;
        reply_t             want;
        reply_t             got;
        int                 bad;
        if (!aresetn) begin
            region_q = '0;
            afc_on_q = 1'b1;
            tout_q   = 31'd1000;
            now_q    = '0;
            count_q  = '0;
            foreach (valid_q[i]) begin
                valid_q[i] = 1'b0;
                start_q[i] = '0;
                end_q[i]   = '0;
                pow_q[i]   = '0;
                area_q[i]  = '0;
                stamp_q[i] = '0;
            end
            replies_due.delete();
            errors  <= 0;
            pending <= 0;
            checked <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_REGION:  region_q = cfg_wdata[1:0];
                    CFG_AFC_EN:  afc_on_q = cfg_wdata[0];
                    CFG_TIMEOUT: tout_q   = cfg_wdata;
                    default: begin
                    end
                endcase
            end
            // Results are compared before new commands are queued: a result can
            // never belong to the command accepted at the same edge.
            if (m_tvalid && m_tready) begin
                got = {m_tdata[1:0], m_tdata[9:2]};
                bad = 0;
                if (replies_due.size() == 0) begin
                    $error("result beat with no command outstanding: status %0d power_dbm %0d",
                           got.status, got.power);
                    bad = 1;
                end else begin
                    want = replies_due.pop_front();
                    if (got.status != want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        bad = bad + 1;
                    end
                    if (got.power != want.power) begin
                        $error("power_dbm: expected %0d, got %0d", want.power, got.power);
                        bad = bad + 1;
                    end
                end
                errors  <= errors + bad;
                checked <= checked + 1;
            end
            if (s_tvalid && s_tready) begin
                apply_command(s_tdata, s_tuser, st, pw);
                want.status = st;
                want.power  = pw;
                replies_due.push_back(want);
            end
            pending <= replies_due.size();
        end
    end

endmodule

/* sim/tx_power_limit_rule_table_tb.sv */
module tx_power_limit_rule_table_tb;

    import tprt_pkg::*;

    localparam int MAX_RULES   = 16;
    localparam int SETTLE      = 32;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 190;
    localparam int HOLD_CYCLES = 300;

    // Commands the block answers without doing anything.
    localparam logic [2:0] ACT_SPARE_A = 3'd6;
    localparam logic [2:0] ACT_SPARE_B = 3'd7;

    localparam logic [1:0] REGION_NONE = 2'd0;
    localparam logic [1:0] REGION_BAD  = 2'd3;

    localparam logic [1:0] PH_REGION [0:N_PHASES-1] = '{
        REGION_FCC, REGION_FCC, REGION_ETSI, REGION_ETSI,
        REGION_NONE, REGION_BAD, REGION_FCC, REGION_ETSI};
    localparam logic PH_AFC [0:N_PHASES-1] = '{
        1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    localparam logic [TOUT_W-1:0] PH_TOUT [0:N_PHASES-1] = '{
        31'd1000, 31'd5, 31'd1, 31'd40, 31'h7FFF_FFFF, 31'd20, 31'd10, 31'h7FFF_FFFF};

    localparam int BAND_EDGE [0:4] = '{5925, 6425, 6525, 6875, 7125};
    localparam logic [GEO_W-1:0] GEO_POOL [0:3] = '{
        16'h0000, 16'hFFFF, 16'h1234, 16'hA5C3};

    typedef struct packed {
        logic               given;
        logic [GEO_W-1:0]   geo;
        logic [POWER_W-1:0] pwr;
        logic [4:0]         idx;
        logic [FREQ_W-1:0]  hi;
        logic [FREQ_W-1:0]  lo;
    } cmd_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [30:0] cfg_wdata;

    int errors;
    int pending;
    int checked;

    bit quiet;
    bit hold_req;
    int n_cmds;
    int n_settings;
    int load_n;

    bit                slot_used [MAX_RULES];
    logic [FREQ_W-1:0] slot_lo   [MAX_RULES];
    logic [FREQ_W-1:0] slot_hi   [MAX_RULES];
    logic [GEO_W-1:0]  slot_geo  [MAX_RULES];

    tx_power_limit_rule_table #(
        .MAX_AFC_RULES(MAX_RULES),
        .AREA_BITS    (GEO_W)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_wdata(cfg_wdata)
    );

    tprt_limit_checker #(
        .MAX_AFC_RULES(MAX_RULES)
    ) rule_check (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_wdata(cfg_wdata),
        .errors   (errors),
        .pending  (pending),
        .checked  (checked)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #6_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Frequencies cluster around the rule edges, where off-by-one errors live.
    function automatic logic [FREQ_W-1:0] pick_freq();
        int r;
        int f;
        r = $urandom_range(0, 9);
        if (r < 4)
            f = BAND_EDGE[$urandom_range(0, 4)] + int'($urandom_range(0, 2)) - 1;
        else if (r < 8)
            f = $urandom_range(5900, 7200);
        else
            f = $urandom_range(0, 16383);
        return f[FREQ_W-1:0];
    endfunction

    function automatic logic [FREQ_W-1:0] upper_of(input logic [FREQ_W-1:0] lo,
                                                   input int span);
        int h;
        h = int'(lo) + span;
        if (h > 16383)
            h = 16383;
        return h[FREQ_W-1:0];
    endfunction

    function automatic logic [POWER_W-1:0] pick_power();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return 8'd255;
        if (r < 6)
            return $urandom_range(10, 40);
        return $urandom_range(0, 255);
    endfunction

    function automatic logic [GEO_W-1:0] pick_geo();
        if ($urandom_range(0, 9) < 8)
            return GEO_POOL[$urandom_range(0, 3)];
        return $urandom_range(0, 65535);
    endfunction

    function automatic cmd_t cmd_of(input logic [FREQ_W-1:0] lo, input logic [FREQ_W-1:0] hi,
                                    input logic [4:0] idx, input logic [POWER_W-1:0] pwr,
                                    input logic [GEO_W-1:0] geo, input logic given);
        cmd_t c;
        c.lo    = lo;
        c.hi    = hi;
        c.idx   = idx;
        c.pwr   = pwr;
        c.geo   = geo;
        c.given = given;
        return c;
    endfunction

    function automatic cmd_t any_cmd();
        logic [FREQ_W-1:0] lo;
        lo = pick_freq();
        return cmd_of(lo, upper_of(lo, $urandom_range(0, 300)), $urandom_range(0, 31),
                      pick_power(), pick_geo(), $urandom_range(0, 1));
    endfunction

    task automatic send_cmd(input logic [2:0] act, input cmd_t c);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {6'b0, c};
        do @(posedge aclk); while (!s_tready);
        n_cmds++;
        // Track what is loaded so that later writes and queries can aim at it.
        if (act == ACT_LOAD && c.idx <= MAX_RULES) begin
            load_n = c.idx;
            foreach (slot_used[i]) slot_used[i] = 1'b0;
        end
        if (act == ACT_WRITE && c.idx < load_n) begin
            slot_used[c.idx] = 1'b1;
            slot_lo[c.idx]   = c.lo;
            slot_hi[c.idx]   = c.hi;
            slot_geo[c.idx]  = c.geo;
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_config(input logic [1:0] region, input logic afc_on,
                              input logic [TOUT_W-1:0] timeout);
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_REGION;
        cfg_wdata <= {29'b0, region};
        @(posedge aclk);
        cfg_idx   <= CFG_AFC_EN;
        cfg_wdata <= {30'b0, afc_on};
        @(posedge aclk);
        cfg_idx   <= CFG_TIMEOUT;
        cfg_wdata <= timeout;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        n_settings++;
    endtask

    // A load of a random count, then random writes to most of its slots.
    task automatic reload_rules();
        cmd_t c;
        int   n;
        c = any_cmd();
        if ($urandom_range(0, 19) < 17)
            n = $urandom_range(1, MAX_RULES);
        else
            n = $urandom_range(MAX_RULES + 1, 31);
        c.idx = n;
        send_cmd(ACT_LOAD, c);
        for (int i = 0; i < n && i < 31; i++) begin
            c     = any_cmd();
            c.idx = i;
            c.hi  = upper_of(c.lo, $urandom_range(0, 1200));
            if ($urandom_range(0, 9) != 0)
                send_cmd(ACT_WRITE, c);
        end
    endtask

    task automatic send_random();
        cmd_t c;
        int   r;
        int   k;
        c = any_cmd();
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 9) < 2)
            c.hi = pick_freq();
        else if ($urandom_range(0, 19) == 0)
            c.hi = c.lo;
        if (r < 20) begin
            send_cmd(ACT_TICK, c);
        end else if (r < 30) begin
            send_cmd(ACT_SWEEP, c);
        end else if (r < 33) begin
            c.idx = ($urandom_range(0, 9) < 7) ? $urandom_range(0, MAX_RULES)
                                                : $urandom_range(0, 31);
            send_cmd(ACT_LOAD, c);
        end else if (r < 43) begin
            if (load_n > 0 && $urandom_range(0, 9) < 8)
                c.idx = $urandom_range(0, load_n - 1);
            c.hi = upper_of(c.lo, $urandom_range(0, 1200));
            send_cmd(ACT_WRITE, c);
        end else if (r < 63) begin
            send_cmd(ACT_CHECK, c);
        end else if (r < 98) begin
            k = $urandom_range(0, MAX_RULES - 1);
            if (slot_used[k] && $urandom_range(0, 1)) begin
                c.lo = slot_lo[k] + $urandom_range(0, 3);
                c.hi = slot_hi[k] - $urandom_range(0, 3);
                if ($urandom_range(0, 9) < 7)
                    c.geo = slot_geo[k];
            end
            send_cmd(ACT_QUERY, c);
        end else begin
            send_cmd(r[0] ? ACT_SPARE_A : ACT_SPARE_B, c);
        end
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial begin : result_ready
        int gap;
        m_tready <= 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            gap = pick_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    initial begin : stimulus
        int  stop_at;
        int  phase_start;
        bit  pressed;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= ACT_TICK;
        cfg_we    <= 1'b0;
        cfg_idx   <= CFG_REGION;
        cfg_wdata <= '0;
        quiet      = 1'b0;
        hold_req   = 1'b0;
        pressed    = 1'b0;
        n_cmds     = 0;
        n_settings = 0;
        load_n     = 0;
        foreach (slot_used[i]) slot_used[i] = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        drain();
        set_config(REGION_FCC, 1'b1, 31'd1000);

        // Directed: count limits, slot limits, area matching, zero power,
        // inverted and out-of-range bands, unused commands.
        send_cmd(ACT_TICK,  cmd_of(0, 0, 0, 0, 0, 0));
        send_cmd(ACT_LOAD,  cmd_of(0, 0, 17, 0, 0, 0));
        send_cmd(ACT_LOAD,  cmd_of(0, 0, 31, 0, 0, 0));
        send_cmd(ACT_LOAD,  cmd_of(0, 0, 3, 0, 0, 0));
        send_cmd(ACT_WRITE, cmd_of(6000, 6400, 3, 20, 16'h1234, 0));
        send_cmd(ACT_WRITE, cmd_of(6000, 6400, 0, 20, 16'h1234, 0));
        send_cmd(ACT_WRITE, cmd_of(0, 16383, 1, 255, 16'hFFFF, 0));
        send_cmd(ACT_WRITE, cmd_of(6600, 6700, 2, 0, 16'h0000, 0));
        send_cmd(ACT_QUERY, cmd_of(6000, 6400, 0, 0, 16'h1234, 1));
        send_cmd(ACT_QUERY, cmd_of(6000, 6400, 0, 0, 16'hFFFF, 1));
        send_cmd(ACT_QUERY, cmd_of(0, 16383, 0, 0, 16'h0000, 0));
        send_cmd(ACT_QUERY, cmd_of(6600, 6700, 0, 0, 16'h0000, 1));
        send_cmd(ACT_QUERY, cmd_of(16383, 16383, 0, 0, 16'h0000, 1));
        send_cmd(ACT_CHECK, cmd_of(6600, 6800, 0, 0, 0, 0));
        send_cmd(ACT_CHECK, cmd_of(7000, 6000, 0, 0, 0, 0));
        send_cmd(ACT_CHECK, cmd_of(16383, 16383, 0, 0, 0, 0));
        send_cmd(ACT_CHECK, cmd_of(0, 0, 0, 0, 0, 0));
        send_cmd(ACT_CHECK, cmd_of(5925, 7125, 0, 0, 0, 0));
        send_cmd(ACT_SWEEP, cmd_of(0, 0, 0, 0, 0, 0));
        send_cmd(ACT_SPARE_A, cmd_of(16383, 16383, 31, 255, 16'hFFFF, 1));
        send_cmd(ACT_SPARE_B, cmd_of(0, 0, 0, 0, 0, 0));
        send_cmd(ACT_LOAD,  cmd_of(0, 0, 16, 0, 0, 0));
        send_cmd(ACT_WRITE, cmd_of(16383, 16383, 15, 255, 16'hFFFF, 1));
        send_cmd(ACT_QUERY, cmd_of(16383, 16383, 31, 255, 16'hFFFF, 1));
        send_cmd(ACT_LOAD,  cmd_of(0, 0, 0, 0, 0, 0));
        send_cmd(ACT_QUERY, cmd_of(6000, 6400, 0, 0, 0, 0));

        for (int p = 0; p < N_PHASES; p++) begin
            drain();
            set_config(PH_REGION[p], PH_AFC[p], PH_TOUT[p]);
            quiet       = (p % 4 == 1);
            phase_start = n_cmds;
            stop_at     = n_cmds + PHASE_ITEMS;
            while (n_cmds < stop_at) begin
                if (quiet && n_cmds - phase_start >= PHASE_ITEMS / 2)
                    quiet = 1'b0;
                if ($urandom_range(0, 99) < 8)
                    reload_rules();
                else
                    send_random();
                // Stall the result side long enough that the input backs up.
                if (p == 0 && !pressed && n_cmds - phase_start >= 10) begin
                    hold_req = 1'b1;
                    pressed  = 1'b1;
                end
            end
        end

        drain();
        $display("Ran %0d commands over %0d register settings, all regions and AFC modes;",
                 n_cmds, n_settings);
        $display("%0d results compared, %0d mismatching fields.", checked, errors);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* tx_power_limit_rule_table.f */
rtl/tprt_pkg.sv
rtl/tprt_ram.sv
rtl/tprt_eval.sv
rtl/tx_power_limit_rule_table.sv
sim/tprt_limit_checker.sv
sim/tx_power_limit_rule_table_tb.sv
